// ===== rtl/mwel_pkg.sv =====
package mwel_pkg;

    localparam int WINDOW_SIZE = 7;
    localparam int PTR_W       = $clog2(WINDOW_SIZE);
    localparam int CNT_W       = $clog2(WINDOW_SIZE + 1);
    localparam int MED_IDX     = WINDOW_SIZE / 2;

    localparam int LAT_W    = 64;
    localparam int SAMPLE_W = 32;
    localparam int FRAC_W   = 16;
    localparam int SMOOTH_W = SAMPLE_W + FRAC_W;
    localparam int ALPHA_W  = 16;
    localparam int PROD_W   = SMOOTH_W + ALPHA_W;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd655;

    // what the smoothing stage does with a median
    typedef struct packed {
        logic load;   // first wrap of the window: smoothed value takes the median
        logic run;    // smoothing already started: one ewma step
    } ewma_ctl_t;

endpackage

// ===== rtl/mwel_if.sv =====
interface mwel_sample_if;
    logic                                valid;
    logic                                ready;
    logic signed [mwel_pkg::LAT_W-1:0]   latency_ns;

    modport source (output valid, output latency_ns, input ready);
    modport sink (input valid, input latency_ns, output ready);
endinterface

interface mwel_result_if;
    logic                                valid;
    logic                                ready;
    logic [mwel_pkg::SMOOTH_W-1:0]       smoothed_q16;
    logic [mwel_pkg::SAMPLE_W-1:0]       median_ns;
    logic                                smoothed_valid;

    modport source (output valid, output smoothed_q16, output median_ns,
                    output smoothed_valid, input ready);
    modport sink (input valid, input smoothed_q16, input median_ns,
                  input smoothed_valid, output ready);
endinterface

interface mwel_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [mwel_pkg::ALPHA_W-1:0]        alpha_q16;

    modport source (output valid, output alpha_q16, input ready);
    modport sink (input valid, input alpha_q16, output ready);
endinterface

// ===== rtl/mwel_median.sv =====
module mwel_median (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [mwel_pkg::SAMPLE_W-1:0] in_sample,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [mwel_pkg::SAMPLE_W-1:0] out_median,
    output mwel_pkg::ewma_ctl_t           out_ctl
);
    import mwel_pkg::*;

    logic [SAMPLE_W-1:0] window_reg [WINDOW_SIZE];
    logic [SAMPLE_W-1:0] window_next [WINDOW_SIZE];
    logic [PTR_W-1:0]    wptr_reg;
    logic [PTR_W-1:0]    wptr_next;
    logic                started_reg;
    logic                valid_reg;
    logic [SAMPLE_W-1:0] median_reg;
    logic [SAMPLE_W-1:0] median_next;
    ewma_ctl_t           ctl_reg;
    ewma_ctl_t           ctl_next;
    logic [CNT_W-1:0]    rank [WINDOW_SIZE];
    logic                wrap;
    logic                fire;

    assign in_ready = !valid_reg || out_ready;
    assign fire     = in_valid && in_ready;

    assign wrap      = (wptr_reg == PTR_W'(WINDOW_SIZE - 1));
    assign wptr_next = wrap ? '0 : wptr_reg + PTR_W'(1);

    always_comb
    begin
        for (int i = 0; i < WINDOW_SIZE; i++)
        begin
            window_next[i] = (wptr_reg == PTR_W'(i)) ? in_sample : window_reg[i];
        end
    end

    // stable rank of each entry; exactly one entry sits at the middle position
    always_comb
    begin
        median_next = '0;
        for (int i = 0; i < WINDOW_SIZE; i++)
        begin
            rank[i] = '0;
            for (int j = 0; j < WINDOW_SIZE; j++)
            begin
                if ((window_next[j] < window_next[i]) ||
                    ((window_next[j] == window_next[i]) && (j < i)))
                begin
                    rank[i] = rank[i] + CNT_W'(1);
                end
            end
            if (rank[i] == CNT_W'(MED_IDX))
            begin
                median_next = median_next | window_next[i];
            end
        end
    end

    assign ctl_next.load = !started_reg && wrap;
    assign ctl_next.run  = started_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_SIZE; i++)
            begin
                window_reg[i] <= '0;
            end
            wptr_reg    <= '0;
            started_reg <= 1'b0;
            valid_reg   <= 1'b0;
            ctl_reg     <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                valid_reg <= in_valid;
            end
            if (fire)
            begin
                window_reg  <= window_next;
                wptr_reg    <= wptr_next;
                started_reg <= started_reg || wrap;
                ctl_reg     <= ctl_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            median_reg <= median_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_median = median_reg;
    assign out_ctl    = ctl_reg;

endmodule

// ===== rtl/mwel_ewma.sv =====
module mwel_ewma (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [mwel_pkg::ALPHA_W-1:0]  alpha,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [mwel_pkg::SAMPLE_W-1:0] in_median,
    input  mwel_pkg::ewma_ctl_t           in_ctl,
    mwel_result_if.source                 result
);
    import mwel_pkg::*;

    logic [SMOOTH_W-1:0] smoothed_reg;
    logic [SMOOTH_W-1:0] smoothed_next;
    logic                started_reg;
    logic                valid_reg;
    logic [SAMPLE_W-1:0] median_reg;
    logic [SMOOTH_W-1:0] med_q;
    logic                above;
    logic [SMOOTH_W-1:0] diff;
    logic [PROD_W-1:0]   prod;
    logic [SMOOTH_W-1:0] step;
    logic                fire;

    assign in_ready = !valid_reg || result.ready;
    assign fire     = in_valid && in_ready;

    assign med_q = {in_median, {FRAC_W{1'b0}}};
    assign above = (med_q >= smoothed_reg);
    assign diff  = above ? (med_q - smoothed_reg) : (smoothed_reg - med_q);
    assign prod  = {{ALPHA_W{1'b0}}, diff} * {{SMOOTH_W{1'b0}}, alpha};
    // step truncates toward zero, so the new value stays between old and median
    assign step  = prod[PROD_W-1:FRAC_W];

    always_comb
    begin
        smoothed_next = smoothed_reg;
        if (in_ctl.load)
        begin
            smoothed_next = med_q;
        end
        else if (in_ctl.run)
        begin
            smoothed_next = above ? (smoothed_reg + step) : (smoothed_reg - step);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smoothed_reg <= '0;
            started_reg  <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                valid_reg <= in_valid;
            end
            if (fire)
            begin
                smoothed_reg <= smoothed_next;
                started_reg  <= started_reg || in_ctl.load;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            median_reg <= in_median;
        end
    end

    // smoothed value stays zero until the first load, so it is the result as is
    assign result.valid          = valid_reg;
    assign result.smoothed_q16   = smoothed_reg;
    assign result.median_ns      = median_reg;
    assign result.smoothed_valid = started_reg;

endmodule

// ===== rtl/median_window_ewma_latency.sv =====
// channel   modport  payload                                   request
// sample    sink     latency_ns[63:0] signed                   one latency sample
// result    source   smoothed_q16[47:0] median_ns[31:0]        one per positive sample
//                    smoothed_valid
// cfg       sink     alpha_q16[15:0]                           ewma weight, always ready
//
// three register stages: sample capture, window write + median, ewma step.
// one sample per cycle unless result stalls; capture, median and ewma are registered.
// each stage holds while the next one is full and stalled, bubbles are squeezed out.
// zero or negative samples are taken but give no result.
// reset clears the window, pointer, smoothed value and loads alpha with 655.
module median_window_ewma_latency (
    input  logic          clk,
    input  logic          rst_n,
    mwel_sample_if.sink   sample,
    mwel_result_if.source result,
    mwel_cfg_if.sink      cfg
);
    import mwel_pkg::*;

    logic [ALPHA_W-1:0]  alpha_reg;
    logic                in_valid_reg;
    logic [SAMPLE_W-1:0] in_sample_reg;
    logic [SAMPLE_W-1:0] sat_sample;
    logic                positive;
    logic                med_ready;
    logic                med_valid;
    logic [SAMPLE_W-1:0] med_value;
    ewma_ctl_t           med_ctl;
    logic                ewma_ready;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= ALPHA_RESET;
        end
        else if (cfg.valid)
        begin
            alpha_reg <= cfg.alpha_q16;
        end
    end

    assign positive   = !sample.latency_ns[LAT_W-1] && (sample.latency_ns != '0);
    assign sat_sample = (|sample.latency_ns[LAT_W-2:SAMPLE_W]) ? '1 :
                        sample.latency_ns[SAMPLE_W-1:0];

    assign sample.ready = !in_valid_reg || med_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            in_valid_reg <= sample.valid && positive;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            in_sample_reg <= sat_sample;
        end
    end

    mwel_median u_median (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid_reg),
        .in_ready   (med_ready),
        .in_sample  (in_sample_reg),
        .out_valid  (med_valid),
        .out_ready  (ewma_ready),
        .out_median (med_value),
        .out_ctl    (med_ctl)
    );

    mwel_ewma u_ewma (
        .clk       (clk),
        .rst_n     (rst_n),
        .alpha     (alpha_reg),
        .in_valid  (med_valid),
        .in_ready  (ewma_ready),
        .in_median (med_value),
        .in_ctl    (med_ctl),
        .result    (result)
    );

endmodule
